// ===== sv/fct_pkg.sv =====
// Shared types, command codes and helper functions for the frustum cull tester.
// It has no dependencies. Every other file uses it through scoped names.
`timescale 1ns / 1ps
`default_nettype none
package fct_pkg;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_REBUILD = 2'd1;
  localparam logic [1:0] CMD_SPHERE  = 2'd2;
  localparam logic [1:0] CMD_BOX     = 2'd3;

  // Number of planes that the extraction table defines.
  localparam int TABLE_PLANES = 6;
  localparam int PIDX_W = 3;

  typedef logic signed [31:0] q16_t;

  // One test item travelling down the chain of plane cells.
  typedef struct packed {
    logic        valid;
    logic        is_box;
    logic        in_view;
    q16_t        lx;
    q16_t        ly;
    q16_t        lz;
    q16_t        hx;
    q16_t        hy;
    q16_t        hz;
    logic [30:0] radius;
  } fct_item_t;

  // Plane coefficient write from the rebuild sequencer to one cell.
  typedef struct packed {
    logic              en;
    logic [PIDX_W-1:0] idx;
    q16_t              a;
    q16_t              b;
    q16_t              c;
    q16_t              d;
  } fct_pwr_t;

  // Matrix column that a plane combines with column 3.
  function automatic logic [1:0] row_col(input logic [PIDX_W-1:0] p);
    logic [1:0] col;
    case (p)
      3'd0, 3'd1: col = 2'd0;
      3'd2, 3'd3: col = 2'd1;
      default:    col = 2'd2;
    endcase
    return col;
  endfunction

  // True when a plane subtracts its column from column 3.
  function automatic logic row_neg(input logic [PIDX_W-1:0] p);
    logic neg;
    case (p)
      3'd0, 3'd3, 3'd4: neg = 1'b1;
      default:          neg = 1'b0;
    endcase
    return neg;
  endfunction

  function automatic q16_t sat32(input logic signed [32:0] v);
    q16_t r;
    if (v > 33'sd2147483647) r = 32'sh7fffffff;
    else if (v < -33'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] mag32(input q16_t v);
    logic [31:0] m;
    m = v[31] ? (32'd0 - 32'(v)) : 32'(v);
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== sv/fct_if.sv =====
// Handshake channel interfaces for the test items and the inside flags.
// They use the q16_t coordinate type of fct_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface fct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [3:0]  elem_index;
  fct_pkg::q16_t elem_value;
  fct_pkg::q16_t x_lo;
  fct_pkg::q16_t y_lo;
  fct_pkg::q16_t z_lo;
  fct_pkg::q16_t x_hi;
  fct_pkg::q16_t y_hi;
  fct_pkg::q16_t z_hi;
  logic [30:0] radius;
  modport source (output valid, cmd, elem_index, elem_value, x_lo, y_lo, z_lo,
                  x_hi, y_hi, z_hi, radius, input ready);
  modport sink (input valid, cmd, elem_index, elem_value, x_lo, y_lo, z_lo,
                x_hi, y_hi, z_hi, radius, output ready);
endinterface

interface fct_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface
`default_nettype wire

// ===== sv/fct_cell.sv =====
// One plane cell of the test chain: holds a plane and tests the passing item.
// Depends on fct_pkg for the item and plane write types.
`timescale 1ns / 1ps
`default_nettype none
module fct_cell #(
  parameter int PLANE_IDX = 0
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                adv,
  input  fct_pkg::fct_pwr_t  pwr,
  input  fct_pkg::fct_item_t item_i,
  output fct_pkg::fct_item_t item_o,
  output logic               busy
);

  fct_pkg::q16_t a_r, b_r, c_r, d_r;
  fct_pkg::fct_item_t s1_r, s2_r;
  logic signed [63:0] pn_r [3];
  logic signed [63:0] pf_r [3];
  logic signed [47:0] dt_r;
  logic [46:0]        et_r;

  fct_pkg::q16_t nx, ny, nz, fx, fy, fz;
  logic signed [66:0] tn, tf;
  fct_pkg::fct_item_t s2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= '0;
      c_r <= '0;
      d_r <= '0;
    end else if (pwr.en && pwr.idx == fct_pkg::PIDX_W'(PLANE_IDX)) begin
      a_r <= pwr.a;
      b_r <= pwr.b;
      c_r <= pwr.c;
      d_r <= pwr.d;
    end
  end

  // The near vertex takes the minimum where the normal points along +axis.
  always_comb begin
    if (item_i.is_box) begin
      nx = (a_r > 0) ? item_i.lx : item_i.hx;
      fx = (a_r > 0) ? item_i.hx : item_i.lx;
      ny = (b_r > 0) ? item_i.ly : item_i.hy;
      fy = (b_r > 0) ? item_i.hy : item_i.ly;
      nz = (c_r > 0) ? item_i.lz : item_i.hz;
      fz = (c_r > 0) ? item_i.hz : item_i.lz;
    end else begin
      nx = item_i.lx;
      fx = item_i.lx;
      ny = item_i.ly;
      fy = item_i.ly;
      nz = item_i.lz;
      fz = item_i.lz;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pn_r[0] <= a_r * nx;
      pn_r[1] <= b_r * ny;
      pn_r[2] <= c_r * nz;
      pf_r[0] <= a_r * fx;
      pf_r[1] <= b_r * fy;
      pf_r[2] <= c_r * fz;
      dt_r    <= {d_r, 16'd0};
      et_r    <= item_i.is_box ? 47'd0 : {item_i.radius, 16'd0};
    end
  end

  always_comb begin
    tn = 67'(pn_r[0]) + 67'(pn_r[1]) + 67'(pn_r[2]) + 67'(dt_r)
         + 67'($signed({1'b0, et_r}));
    tf = 67'(pf_r[0]) + 67'(pf_r[1]) + 67'(pf_r[2]) + 67'(dt_r)
         + 67'($signed({1'b0, et_r}));
    s2_nxt = s1_r;
    s2_nxt.in_view = s1_r.in_view & ~(tn[66] & tf[66]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else if (adv) begin
      s1_r <= item_i;
      s2_r <= s2_nxt;
    end
  end

  assign item_o = s2_r;
  assign busy   = s1_r.valid | s2_r.valid;

endmodule
`default_nettype wire

// ===== sv/fct_rebuild.sv =====
// Matrix store and plane rebuild sequencer with iterative square root and divider.
// Depends on fct_pkg for the plane table, saturation and write types.
`timescale 1ns / 1ps
`default_nettype none
module fct_rebuild #(
  parameter int NUM_PLANES = 6
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               ld_en,
  input  wire [3:0]         ld_idx,
  input  fct_pkg::q16_t     ld_val,
  input  wire               start,
  input  wire               chain_busy,
  output logic              busy,
  output fct_pkg::fct_pwr_t pwr
);

  localparam int BUILT = (NUM_PLANES < fct_pkg::TABLE_PLANES) ? NUM_PLANES
                                                               : fct_pkg::TABLE_PLANES;
  localparam logic [fct_pkg::PIDX_W-1:0] LAST = fct_pkg::PIDX_W'(BUILT - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DRAIN = 3'd1;
  localparam logic [2:0] ST_COEF  = 3'd2;
  localparam logic [2:0] ST_SQ    = 3'd3;
  localparam logic [2:0] ST_SQRT  = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_WRITE = 3'd6;

  fct_pkg::q16_t m_r [16];
  logic [2:0] state_r, state_nxt;
  logic [fct_pkg::PIDX_W-1:0] plane_r, plane_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [5:0]  iter_r, iter_nxt;
  fct_pkg::q16_t co_r [4];
  fct_pkg::q16_t co_nxt [4];
  fct_pkg::q16_t res_r [4];
  fct_pkg::q16_t res_nxt [4];
  logic [63:0] acc_r, acc_nxt, v_r, v_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic [31:0] len_r, len_nxt, rem_r, rem_nxt;
  logic [47:0] dvd_r, dvd_nxt, quo_r, quo_nxt;

  logic [1:0]  col;
  logic        neg;
  logic [63:0] prod, trial;
  logic [32:0] rem_s;
  logic        ge;
  logic [31:0] mk;
  fct_pkg::q16_t qsat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) m_r[i] <= '0;
    end else if (ld_en) begin
      m_r[ld_idx] <= ld_val;
    end
  end

  always_comb begin
    state_nxt = state_r;
    plane_nxt = plane_r;
    k_nxt     = k_r;
    iter_nxt  = iter_r;
    co_nxt    = co_r;
    res_nxt   = res_r;
    acc_nxt   = acc_r;
    v_nxt     = v_r;
    root_nxt  = root_r;
    bit_nxt   = bit_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    quo_nxt   = quo_r;
    col   = fct_pkg::row_col(plane_r);
    neg   = fct_pkg::row_neg(plane_r);
    mk    = fct_pkg::mag32(co_r[k_r]);
    prod  = 64'(mk) * 64'(mk);
    trial = root_r + bit_r;
    rem_s = {rem_r, dvd_r[47]};
    ge    = rem_s >= {1'b0, len_r};
    qsat  = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_DRAIN;
          plane_nxt = '0;
        end
      end
      ST_DRAIN: begin
        if (!chain_busy) state_nxt = ST_COEF;
      end
      ST_COEF: begin
        for (int k = 0; k < 4; k++) begin
          if (neg)
            co_nxt[k] = fct_pkg::sat32(33'(m_r[{2'(k), 2'd3}]) - 33'(m_r[{2'(k), col}]));
          else
            co_nxt[k] = fct_pkg::sat32(33'(m_r[{2'(k), 2'd3}]) + 33'(m_r[{2'(k), col}]));
        end
        acc_nxt   = '0;
        k_nxt     = '0;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        acc_nxt = acc_r + prod;
        k_nxt   = k_r + 2'd1;
        if (k_r == 2'd2) begin
          v_nxt     = acc_r + prod;
          root_nxt  = '0;
          bit_nxt   = 64'd1 << 62;
          iter_nxt  = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (v_r >= trial) begin
          v_nxt    = v_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt  = bit_r >> 2;
        iter_nxt = iter_r + 6'd1;
        if (iter_r == 6'd31) begin
          len_nxt = root_nxt[31:0];
          k_nxt   = '0;
          if (root_nxt[31:0] == 32'd0) begin
            res_nxt   = co_r;
            state_nxt = ST_WRITE;
          end else begin
            dvd_nxt   = {fct_pkg::mag32(co_r[0]), 16'd0};
            rem_nxt   = '0;
            quo_nxt   = '0;
            iter_nxt  = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt  = ge ? 32'(rem_s - {1'b0, len_r}) : rem_s[31:0];
        quo_nxt  = {quo_r[46:0], ge};
        dvd_nxt  = {dvd_r[46:0], 1'b0};
        iter_nxt = iter_r + 6'd1;
        if (iter_r == 6'd47) begin
          if (!co_r[k_r][31])
            qsat = (|quo_nxt[47:31]) ? 32'sh7fffffff : $signed({1'b0, quo_nxt[30:0]});
          else if ((|quo_nxt[47:32]) || (quo_nxt[31] && (|quo_nxt[30:0])))
            qsat = 32'sh80000000;
          else
            qsat = $signed(32'd0 - quo_nxt[31:0]);
          res_nxt[k_r] = qsat;
          k_nxt        = k_r + 2'd1;
          if (k_r == 2'd3) begin
            state_nxt = ST_WRITE;
          end else begin
            dvd_nxt  = {fct_pkg::mag32(co_r[k_r + 2'd1]), 16'd0};
            rem_nxt  = '0;
            quo_nxt  = '0;
            iter_nxt = '0;
          end
        end
      end
      ST_WRITE: begin
        plane_nxt = plane_r + 1'b1;
        state_nxt = (plane_r == LAST) ? ST_IDLE : ST_COEF;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      plane_r <= '0;
    end else begin
      state_r <= state_nxt;
      plane_r <= plane_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    iter_r <= iter_nxt;
    co_r   <= co_nxt;
    res_r  <= res_nxt;
    acc_r  <= acc_nxt;
    v_r    <= v_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
    len_r  <= len_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    quo_r  <= quo_nxt;
  end

  assign busy    = state_r != ST_IDLE;
  assign pwr.en  = state_r == ST_WRITE;
  assign pwr.idx = plane_r;
  assign pwr.a   = res_r[0];
  assign pwr.b   = res_r[1];
  assign pwr.c   = res_r[2];
  assign pwr.d   = res_r[3];

endmodule
`default_nettype wire

// ===== sv/frustum_cull_tester.sv =====
// Top level of the frustum cull tester: input decode, chain of plane cells, output register.
// Depends on fct_pkg, fct_if, fct_cell and fct_rebuild.
//
// The tester accepts one command per transfer. A load writes one element of the 4x4
// view-projection matrix and a rebuild derives the clip planes from it; neither
// gives a result. A sphere test (radius zero is a point test) or an axis-aligned
// box test gives one inside flag, in command order. Tests sustain one transfer per
// cycle while the output is drained and no rebuild runs: each plane lives in a cell
// of a chain, an item passes each cell's s1 and s2 registers, and its flag then
// waits in the output register. A rebuild holds off input while the chain drains,
// then runs a sequencer per plane: the sums, the squared norm, the square root and
// the divider per coefficient, with no divider for a plane with a zero normal, over
// at most six planes. Planes beyond the sixth stay zero and never reject, but cells
// from the ninth on match the plane index modulo eight. Coordinates are
// read as COORD_WIDTH-bit two's complement values from the low field bits.
`timescale 1ns / 1ps
`default_nettype none
module frustum_cull_tester #(
  parameter int NUM_PLANES  = 6,
  parameter int COORD_WIDTH = 32
) (
  input wire        clk,
  input wire        rst_n,
  fct_in_if.sink    in_if,
  fct_out_if.source out_if
);

  // Widths above 32 act as 32 since the fields carry 32 bits.
  localparam int CW = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;

  fct_pkg::fct_item_t chain [NUM_PLANES+1];
  fct_pkg::fct_item_t head;
  fct_pkg::fct_pwr_t  pwr;
  logic [NUM_PLANES-1:0] cell_busy;
  logic chain_busy, rb_busy, adv, in_acc, test_acc;
  logic out_valid_r, out_valid_nxt, out_inside_r, out_inside_nxt;

  // The chain moves whenever the output register is free or being drained.
  assign adv      = !out_valid_r || out_if.ready;
  assign in_if.ready = adv && !rb_busy;
  assign in_acc   = in_if.valid && in_if.ready;
  assign test_acc = in_acc && (in_if.cmd == fct_pkg::CMD_SPHERE ||
                               in_if.cmd == fct_pkg::CMD_BOX);
  assign chain_busy = |cell_busy;

  always_comb begin
    head.valid   = test_acc;
    head.is_box  = in_if.cmd == fct_pkg::CMD_BOX;
    head.in_view = 1'b1;
    head.lx      = 32'($signed(in_if.x_lo[CW-1:0]));
    head.ly      = 32'($signed(in_if.y_lo[CW-1:0]));
    head.lz      = 32'($signed(in_if.z_lo[CW-1:0]));
    head.hx      = 32'($signed(in_if.x_hi[CW-1:0]));
    head.hy      = 32'($signed(in_if.y_hi[CW-1:0]));
    head.hz      = 32'($signed(in_if.z_hi[CW-1:0]));
    head.radius  = in_if.radius;
  end

  assign chain[0] = head;

  fct_rebuild #(.NUM_PLANES(NUM_PLANES)) u_rebuild (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld_en      (in_acc && in_if.cmd == fct_pkg::CMD_LOAD),
    .ld_idx     (in_if.elem_index),
    .ld_val     (in_if.elem_value),
    .start      (in_acc && in_if.cmd == fct_pkg::CMD_REBUILD),
    .chain_busy (chain_busy),
    .busy       (rb_busy),
    .pwr        (pwr)
  );

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
    fct_cell #(.PLANE_IDX(p)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .pwr    (pwr),
      .item_i (chain[p]),
      .item_o (chain[p+1]),
      .busy   (cell_busy[p])
    );
  end

  // Output register: a finished flag waits here, and the chain holds, until it is taken.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_inside_nxt = out_inside_r;
    if (adv) begin
      out_valid_nxt  = chain[NUM_PLANES].valid;
      out_inside_nxt = chain[NUM_PLANES].in_view;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    out_inside_r <= out_inside_nxt;
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.inside_res = out_inside_r;

`ifndef SYNTHESIS
  // Planes change only while no test is in flight.
  a_write_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pwr.en |-> !chain_busy) else $error("plane write while tests in flight");
  // A test transfer enters the first cell.
  a_test_enters: assert property (@(posedge clk) disable iff (!rst_n)
    test_acc |=> cell_busy[0]) else $error("test transfer lost at chain entry");
  // A rebuild transfer starts the sequencer and blocks input.
  a_rebuild_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_if.cmd == fct_pkg::CMD_REBUILD) |=> (rb_busy && !in_if.ready))
    else $error("rebuild did not start");
`endif

endmodule
`default_nettype wire
